/* hdl/jafd_pkg.sv */
// ----------------------------------------------------------------------------
// jafd_pkg
// Shared types, constants and helpers for the joint angle block.
// ----------------------------------------------------------------------------
package jafd_pkg;

    localparam int CORDIC_STEPS_DEF = 18;
    localparam int MAX_STEPS        = 30;
    localparam int QUEUE_DEPTH      = 2;

    // CORDIC datapath: 24-bit operand shifted up 30 bits plus gain headroom
    localparam int VW = 57;
    localparam int ZW = 35;

    localparam logic signed [ZW-1:0] ANG_PI      = 35'sd3373259426;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 35'sd1686629713;
    localparam logic signed [ZW-1:0] ANG_ROUND   = 35'sd8192;
    localparam logic signed [20:0]   ANG_LIMIT   = 21'sd205888;

    localparam logic [7:0] CFG_MIN_DIR_NORM_SQ   = 8'd0;
    localparam logic [7:0] CFG_MAX_POINT_NORM_SQ = 8'd1;

    localparam logic [47:0] MIN_DIR_RST   = 48'd1;
    localparam logic [62:0] MAX_POINT_RST = 63'd6553600000000;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_lane;

    typedef struct packed {
        logic               ok;
        logic signed [32:0] ext;
        t_lane              roll;
        t_lane              pitch;
    } t_item;

    // atan(2^-i) in Q2.30
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 35'sd843314856;
            1:  v = 35'sd497837829;
            2:  v = 35'sd263043836;
            3:  v = 35'sd133525158;
            4:  v = 35'sd67021686;
            5:  v = 35'sd33543515;
            6:  v = 35'sd16775850;
            7:  v = 35'sd8388437;
            8:  v = 35'sd4194282;
            9:  v = 35'sd2097149;
            10: v = 35'sd1048576;
            11: v = 35'sd524288;
            12: v = 35'sd262144;
            13: v = 35'sd131072;
            14: v = 35'sd65536;
            15: v = 35'sd32768;
            16: v = 35'sd16384;
            17: v = 35'sd8192;
            18: v = 35'sd4096;
            19: v = 35'sd2048;
            20: v = 35'sd1024;
            21: v = 35'sd512;
            22: v = 35'sd256;
            23: v = 35'sd128;
            24: v = 35'sd64;
            25: v = 35'sd32;
            26: v = 35'sd16;
            27: v = 35'sd8;
            28: v = 35'sd4;
            29: v = 35'sd2;
            30: v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Quadrant fold. Axis cases leave y at zero so every rotation is skipped.
    function automatic t_lane lane_prep(input logic signed [23:0] num,
                                        input logic signed [23:0] den);
        t_lane             l;
        logic signed [24:0] n25;
        logic signed [24:0] d25;
        n25 = {num[23], num};
        d25 = {den[23], den};
        l.x = '0;
        l.y = '0;
        l.z = '0;
        if (num == 24'sd0) begin
            l.z = den[23] ? ANG_PI : '0;
        end else if (den == 24'sd0) begin
            l.z = num[23] ? -ANG_HALF_PI : ANG_HALF_PI;
        end else begin
            if (den[23]) begin
                l.z = num[23] ? -ANG_PI : ANG_PI;
                n25 = -n25;
                d25 = -d25;
            end
            l.x = {{(VW-55){d25[24]}}, d25, 30'b0};
            l.y = {{(VW-55){n25[24]}}, n25, 30'b0};
        end
        return l;
    endfunction

endpackage

/* hdl/joint_angles_from_direction_top.sv */
// Path: input, square and item registers, queue, CORDIC stages, result strobe.
// Throughput: one command per cycle unless busy; the unrolled CORDIC pipeline,
// one stage per micro-rotation, sets the latency. The receiver cannot stall.
// Reset: synchronous active low; clears pipeline valids and the queue and
// loads both config registers with their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// joint_angles_from_direction_top
// Roll, pitch and extension of a tool from a direction vector and a point.
// ----------------------------------------------------------------------------
module joint_angles_from_direction_top #(
    parameter int CORDIC_STEPS = jafd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [23:0]   i_dir_x,
    input  logic signed [23:0]   i_dir_y,
    input  logic signed [23:0]   i_dir_z,
    input  logic signed [31:0]   i_point_x,
    input  logic signed [31:0]   i_point_y,
    input  logic signed [31:0]   i_point_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output logic                 o_valid,
    output logic                 o_ok,
    output logic signed [32:0]   o_extension,
    output logic signed [18:0]   o_roll_angle,
    output logic signed [18:0]   o_pitch_angle
);
    import jafd_pkg::*;

    logic  w_take, w_push, w_qv, w_full;
    t_item w_fitem, w_qitem;

    // back never stalls, so the queue holds at most one word
    assign busy        = w_full;
    assign w_take      = start && !busy;
    assign o_cfg_ready = 1'b1;

    jafd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_dir_x     (i_dir_x),
        .i_dir_y     (i_dir_y),
        .i_dir_z     (i_dir_z),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (w_push),
        .o_item      (w_fitem)
    );

    jafd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fitem),
        .i_pop   (1'b1),
        .o_valid (w_qv),
        .o_full  (w_full),
        .o_item  (w_qitem)
    );

    jafd_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_qv),
        .i_item        (w_qitem),
        .o_valid       (o_valid),
        .o_ok          (o_ok),
        .o_extension   (o_extension),
        .o_roll_angle  (o_roll_angle),
        .o_pitch_angle (o_pitch_angle)
    );

endmodule

/* hdl/jafd_front.sv */
// ----------------------------------------------------------------------------
// jafd_front
// Takes commands, holds the config registers, runs the norm checks and
// folds both angle vectors into the right half plane.
// ----------------------------------------------------------------------------
module jafd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic signed [23:0]   i_dir_x,
    input  logic signed [23:0]   i_dir_y,
    input  logic signed [23:0]   i_dir_z,
    input  logic signed [31:0]   i_point_x,
    input  logic signed [31:0]   i_point_y,
    input  logic signed [31:0]   i_point_z,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output logic                 o_push,
    output jafd_pkg::t_item      o_item
);
    import jafd_pkg::*;

    logic [47:0] r_min_dir;
    logic [62:0] r_max_pt;

    logic               r_v1, r_v2, r_v3;
    logic signed [23:0] r_dx, r_dy, r_dz;
    logic signed [31:0] r_px, r_py, r_pz;

    logic signed [47:0] w_sdx, w_sdy, w_sdz;
    logic signed [63:0] w_spx, w_spy, w_spz;
    logic [47:0]        r_sdx, r_sdy, r_sdz;
    logic [63:0]        r_spx, r_spy, r_spz;
    logic signed [32:0] r_ext2;
    t_lane              r_roll2, r_pitch2;

    logic [47:0] w_dn;
    logic [63:0] w_pn;
    logic        w_ok;
    t_item       r_item;

    assign w_sdx = r_dx * r_dx;
    assign w_sdy = r_dy * r_dy;
    assign w_sdz = r_dz * r_dz;
    assign w_spx = r_px * r_px;
    assign w_spy = r_py * r_py;
    assign w_spz = r_pz * r_pz;

    assign w_dn = r_sdx + r_sdy + r_sdz;
    assign w_pn = r_spx + r_spy + r_spz;
    assign w_ok = (w_dn >= r_min_dir) && (w_pn <= {1'b0, r_max_pt});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dir <= MIN_DIR_RST;
            r_max_pt  <= MAX_POINT_RST;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MIN_DIR_NORM_SQ:   r_min_dir <= i_cfg_data[47:0];
                    CFG_MAX_POINT_NORM_SQ: r_max_pt  <= i_cfg_data[62:0];
                    default: ;
                endcase
            end
            r_v1 <= i_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_dx <= i_dir_x;
            r_dy <= i_dir_y;
            r_dz <= i_dir_z;
            r_px <= i_point_x;
            r_py <= i_point_y;
            r_pz <= i_point_z;
        end
        r_sdx    <= w_sdx;
        r_sdy    <= w_sdy;
        r_sdz    <= w_sdz;
        r_spx    <= w_spx;
        r_spy    <= w_spy;
        r_spz    <= w_spz;
        r_ext2   <= {r_pz, 1'b0};
        r_roll2  <= lane_prep(r_dy, r_dz);
        r_pitch2 <= lane_prep(r_dx, r_dz);
        r_item.ok    <= w_ok;
        r_item.ext   <= w_ok ? r_ext2 : '0;
        r_item.roll  <= r_roll2;
        r_item.pitch <= r_pitch2;
    end

    assign o_push = r_v3;
    assign o_item = r_item;

endmodule

/* hdl/jafd_queue.sv */
// ----------------------------------------------------------------------------
// jafd_queue
// Small FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module jafd_queue #(
    parameter int DEPTH = jafd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  jafd_pkg::t_item  i_item,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output jafd_pkg::t_item  o_item
);
    import jafd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [0:DEPTH-1];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_count;
    logic          w_pop;

    assign w_pop   = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

/* hdl/jafd_back.sv */
// ----------------------------------------------------------------------------
// jafd_back
// Unrolled CORDIC vectoring pipeline, one stage per micro-rotation, two lanes,
// followed by rounding, clamping and the result register.
// ----------------------------------------------------------------------------
module jafd_back #(
    parameter int CORDIC_STEPS = jafd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  jafd_pkg::t_item      i_item,
    output logic                 o_valid,
    output logic                 o_ok,
    output logic signed [32:0]   o_extension,
    output logic signed [18:0]   o_roll_angle,
    output logic signed [18:0]   o_pitch_angle
);
    import jafd_pkg::*;

    function automatic t_lane rot(input t_lane a, input int i);
        t_lane              b;
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;
        xs = a.x >>> i;
        ys = a.y >>> i;
        b  = a;
        if (!a.y[VW-1] && (a.y != '0)) begin
            b.x = a.x + ys;
            b.y = a.y - xs;
            b.z = a.z + atan_q30(i);
        end else if (a.y[VW-1]) begin
            b.x = a.x - ys;
            b.y = a.y + xs;
            b.z = a.z - atan_q30(i);
        end
        return b;
    endfunction

    // Q2.30 to Q3.16, round half up, clamp to +-pi
    function automatic logic signed [20:0] to_q16(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] zr;
        logic signed [20:0]   r;
        zr = z + ANG_ROUND;
        r  = zr[ZW-1:14];
        if (r > ANG_LIMIT) begin
            r = ANG_LIMIT;
        end else if (r < -ANG_LIMIT) begin
            r = -ANG_LIMIT;
        end
        return r;
    endfunction

    t_item r_stage [0:CORDIC_STEPS-1];
    logic  r_sv    [0:CORDIC_STEPS-1];

    genvar g;
    for (g = 0; g < CORDIC_STEPS; g++) begin : g_stage
        t_item w_in;
        logic  w_v;
        if (g == 0) begin : g_first
            assign w_in = i_item;
            assign w_v  = i_valid;
        end else begin : g_next
            assign w_in = r_stage[g-1];
            assign w_v  = r_sv[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[g] <= 1'b0;
            end else begin
                r_sv[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_stage[g].ok    <= w_in.ok;
            r_stage[g].ext   <= w_in.ext;
            r_stage[g].roll  <= rot(w_in.roll, g);
            r_stage[g].pitch <= rot(w_in.pitch, g);
        end
    end

    t_item              w_last;
    logic signed [20:0] w_roll, w_pitch;
    logic signed [20:0] w_nroll;

    assign w_last  = r_stage[CORDIC_STEPS-1];
    assign w_roll  = to_q16(w_last.roll.z);
    assign w_pitch = to_q16(w_last.pitch.z);
    assign w_nroll = -w_roll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_sv[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_ok          <= w_last.ok;
        o_extension   <= w_last.ext;
        o_roll_angle  <= w_last.ok ? w_nroll[18:0] : '0;
        o_pitch_angle <= w_last.ok ? w_pitch[18:0] : '0;
    end

endmodule
